/* rtl/core/entity_id_allocator_with_tags_core_assert.svh */
// Assertion macros shared by the allocator core.
`ifndef ENTITY_ID_ALLOCATOR_WITH_TAGS_CORE_ASSERT_SVH
`define ENTITY_ID_ALLOCATOR_WITH_TAGS_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define EIDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/eida_pkg.sv */
// Types and constants of the ID allocator core.
package eida_pkg;

  localparam int ENTITY_W = 10;
  localparam int TAG_IO_W = 32;
  localparam int NEW_ID_W = 10;
  localparam int LIVE_W   = 11;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_SET_TAG = 2'd2,
    KIND_GET_TAG = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_FREE   = 2'd1,
    STAT_LIST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    kind_t                kind;
    logic [ENTITY_W-1:0]  entity;
    logic [TAG_IO_W-1:0]  tag_in;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [NEW_ID_W-1:0]  new_id;
    logic [TAG_IO_W-1:0]  tag_out;
    logic [LIVE_W-1:0]    live_count;
  } rsp_t;

  // Commit strobes into the free ring
  typedef struct packed {
    logic pop;
    logic push;
  } ring_op_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

/* rtl/core/eida_stream_if.sv */
// Valid/ready channel carrying one payload beat.
interface eida_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/entity_id_allocator_with_tags_core.sv */
// Channel   | Dir | Payload                                   | Beat when
// in_chan   | in  | kind, entity, tag_in                      | valid && ready
// out_chan  | out | status, new_id, tag_out, live_count       | valid && ready
//
// One result per request; sustained rate one request per cycle when the output does not stall
// (RAM read at accept into the request stage, then modify/write-back into the output register).
// After reset the tag RAM is swept to zero, all MAX_IDS entries, with in_chan.ready low.
// Write forwarding covers a RAM read and write to the same entry in one cycle.
// A stalled output holds the result; the request stage then holds and in_chan.ready drops.
`include "entity_id_allocator_with_tags_core_assert.svh"

module entity_id_allocator_with_tags_core #(
  parameter int MAX_IDS  = 1024,
  parameter int TAG_BITS = 32
) (
  input logic           clk,
  input logic           rst_n,
  eida_stream_if.sink   in_chan,
  eida_stream_if.source out_chan
);
  import eida_pkg::*;

  localparam int ID_W  = $clog2(MAX_IDS);
  localparam int CNT_W = $clog2(MAX_IDS + 1);

  logic                s1_vld_r;
  req_t                s1_req_r;
  logic                out_vld_r;
  rsp_t                out_rsp_r;
  rsp_t                rsp_nxt;
  logic [CNT_W-1:0]    live_r, live_nxt;

  logic                in_acc;
  logic                s1_adv;
  logic                ent_ok;
  logic [ID_W-1:0]     s1_idx;

  ring_op_t            ring_op;
  ring_stat_t          ring_stat;
  logic [ID_W-1:0]     pop_id;

  logic                tag_we;
  logic [TAG_BITS-1:0] tag_wd;
  logic [TAG_BITS-1:0] tag_rd;
  logic                tag_busy;

  assign s1_adv        = s1_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !tag_busy && (!s1_vld_r || s1_adv);
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign ent_ok = (32'(s1_req_r.entity) < 32'(MAX_IDS));
  assign s1_idx = ID_W'(s1_req_r.entity);

  always_comb begin
    ring_op         = '0;
    tag_we          = 1'b0;
    tag_wd          = '0;
    live_nxt        = live_r;
    rsp_nxt         = '0;
    rsp_nxt.status  = STAT_OK;
    unique case (s1_req_r.kind)
      KIND_ALLOC: begin
        if (ring_stat.empty) begin
          rsp_nxt.status = STAT_NO_FREE;
        end else begin
          ring_op.pop    = s1_adv;
          rsp_nxt.new_id = NEW_ID_W'(pop_id);
          live_nxt       = live_r + 1'b1;
        end
      end
      KIND_RELEASE: begin
        if (ent_ok) begin
          if (ring_stat.full) begin
            rsp_nxt.status = STAT_LIST_FULL;
          end else begin
            ring_op.push = s1_adv;
            tag_we       = s1_adv;
            if (live_r != '0) begin
              live_nxt = live_r - 1'b1;
            end
          end
        end
      end
      KIND_SET_TAG: begin
        if (ent_ok) begin
          tag_we = s1_adv;
          tag_wd = TAG_BITS'(s1_req_r.tag_in);
        end
      end
      KIND_GET_TAG: begin
        if (ent_ok) begin
          rsp_nxt.tag_out = TAG_IO_W'(tag_rd);
        end
      end
      default: begin
        rsp_nxt.status = STAT_OK;
      end
    endcase
    rsp_nxt.live_count = LIVE_W'(live_nxt);
  end

  eida_ring #(
    .MAX_IDS (MAX_IDS),
    .ID_W    (ID_W),
    .CNT_W   (CNT_W)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .op      (ring_op),
    .push_id (s1_idx),
    .pop_id  (pop_id),
    .stat    (ring_stat)
  );

  eida_tags #(
    .MAX_IDS  (MAX_IDS),
    .ID_W     (ID_W),
    .TAG_BITS (TAG_BITS)
  ) u_tags (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (ID_W'(in_chan.payload.entity)),
    .we      (tag_we),
    .wr_addr (s1_idx),
    .wr_data (tag_wd),
    .rd_data (tag_rd),
    .busy    (tag_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      live_r    <= '0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
        live_r    <= live_nxt;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= in_chan.payload;
    end
    if (s1_adv) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_chan.valid   = out_vld_r;
  assign out_chan.payload = out_rsp_r;

  `EIDA_ASSERT_NOW(a_no_beat_in_clear, tag_busy, !in_acc, "request beat during tag clear")
  `EIDA_ASSERT_NEXT(a_adv_loads_out, s1_adv, out_vld_r, "result lost after request stage")
  `EIDA_ASSERT_NOW(a_full_means_idle, ring_stat.full, live_r == '0, "full free list with live IDs")
  `EIDA_ASSERT_NOW(a_pop_not_empty, ring_op.pop, !ring_stat.empty && !ring_op.push, "bad ring op")

endmodule

/* rtl/core/eida_ring.sv */
// Free ID ring: synchronous RAM, pointers, counts and write forwarding.
module eida_ring #(
  parameter int MAX_IDS = 1024,
  parameter int ID_W    = 10,
  parameter int CNT_W   = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  eida_pkg::ring_op_t   op,
  input  logic [ID_W-1:0]      push_id,
  output logic [ID_W-1:0]      pop_id,
  output eida_pkg::ring_stat_t stat
);
  import eida_pkg::*;

  logic [ID_W-1:0]  ring_mem_r [MAX_IDS];
  logic [ID_W-1:0]  rd_q_r;
  logic [ID_W-1:0]  head_r, head_nxt;
  logic [ID_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0] free_r, free_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             lw_vld_r;
  logic [ID_W-1:0]  lw_addr_r;
  logic [ID_W-1:0]  lw_data_r;
  logic [ID_W-1:0]  head_succ;

  function automatic logic [ID_W-1:0] ring_next(input logic [ID_W-1:0] pos);
    ring_next = (pos == ID_W'(MAX_IDS - 1)) ? '0 : pos + 1'b1;
  endfunction

  assign head_nxt  = op.pop  ? ring_next(head_r) : head_r;
  assign tail_nxt  = op.push ? ring_next(tail_r) : tail_r;
  assign free_nxt  = op.push ? free_r + 1'b1 : (op.pop ? free_r - 1'b1 : free_r);
  assign fill_nxt  = (op.push && fill_r != CNT_W'(MAX_IDS)) ? fill_r + 1'b1 : fill_r;
  assign head_succ = ring_next(head_r);

  // Slot s holds ring_next(s) until first pushed; pushes fill slots N-1, 0, 1, ... in order,
  // so slot s has been written once the push count passes ring_next(s).
  always_comb begin
    if (lw_vld_r && lw_addr_r == head_r) begin
      pop_id = lw_data_r;
    end else if (fill_r > CNT_W'(head_succ)) begin
      pop_id = rd_q_r;
    end else begin
      pop_id = head_succ;
    end
  end

  assign stat.empty = (free_r == '0);
  assign stat.full  = (free_r == CNT_W'(MAX_IDS));

  always_ff @(posedge clk) begin
    if (op.push) begin
      ring_mem_r[tail_r] <= push_id;
    end
    if (rd_en) begin
      rd_q_r <= ring_mem_r[head_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= ID_W'(MAX_IDS - 1);
      free_r   <= CNT_W'(MAX_IDS - 1);
      fill_r   <= '0;
      lw_vld_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      free_r <= free_nxt;
      fill_r <= fill_nxt;
      if (op.push) begin
        lw_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.push) begin
      lw_addr_r <= tail_r;
      lw_data_r <= push_id;
    end
  end

endmodule

/* rtl/core/eida_tags.sv */
// Tag word RAM with post-reset clearing sweep and write forwarding.
module eida_tags #(
  parameter int MAX_IDS  = 1024,
  parameter int ID_W     = 10,
  parameter int TAG_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [ID_W-1:0]     rd_addr,
  input  logic                we,
  input  logic [ID_W-1:0]     wr_addr,
  input  logic [TAG_BITS-1:0] wr_data,
  output logic [TAG_BITS-1:0] rd_data,
  output logic                busy
);
  import eida_pkg::*;

  logic [TAG_BITS-1:0] tag_mem_r [MAX_IDS];
  logic [TAG_BITS-1:0] rd_q_r;
  logic [ID_W-1:0]     rd_addr_r;
  logic                clr_busy_r;
  logic [ID_W-1:0]     clr_addr_r;
  logic                lw_vld_r;
  logic [ID_W-1:0]     lw_addr_r;
  logic [TAG_BITS-1:0] lw_data_r;
  logic                mem_we;
  logic [ID_W-1:0]     mem_wa;
  logic [TAG_BITS-1:0] mem_wd;

  assign mem_we = clr_busy_r || we;
  assign mem_wa = clr_busy_r ? clr_addr_r : wr_addr;
  assign mem_wd = clr_busy_r ? '0 : wr_data;
  assign busy   = clr_busy_r;

  // RAM read returns old data on a same-cycle write; last write wins
  assign rd_data = (lw_vld_r && lw_addr_r == rd_addr_r) ? lw_data_r : rd_q_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem_r[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q_r    <= tag_mem_r[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      lw_vld_r   <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        if (clr_addr_r == ID_W'(MAX_IDS - 1)) begin
          clr_busy_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + 1'b1;
        end
      end
      if (we && !clr_busy_r) begin
        lw_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we && !clr_busy_r) begin
      lw_addr_r <= wr_addr;
      lw_data_r <= wr_data;
    end
  end

endmodule

/* tb/sv/tb.sv */
// Testbench for the tagged ID allocator core: directed, exhaustion, random and backpressure.
module tb;
  import eida_pkg::*;

  localparam int ID_SPACE   = 1024;
  localparam int WDOG_LIMIT = 5000;
  localparam int MAX_SHOWN  = 10;
  localparam int HOLD_LEN   = 200;

  logic clk;
  logic rst_n;

  eida_stream_if #(.payload_t(req_t)) req_ch ();
  eida_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  entity_id_allocator_with_tags_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_ch),
    .out_chan (rsp_ch)
  );

  // Shadow of the allocator state
  logic [ENTITY_W-1:0] free_fifo [ID_SPACE];
  logic [ENTITY_W-1:0] fifo_rd;
  logic [ENTITY_W-1:0] fifo_wr;
  logic [LIVE_W-1:0]   free_n;
  logic [LIVE_W-1:0]   live_n;
  logic [TAG_IO_W-1:0] tag_mem [ID_SPACE];

  rsp_t                rsp_due [$];
  logic [ENTITY_W-1:0] held_ids [$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int hold_left;
  int idle_cycles;
  int errors;
  int shown;
  int n_results;
  int n_no_free;
  int n_list_full;
  int kind_cnt [4];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void alloc_model_reset();
    for (int i = 0; i < ID_SPACE; i++) begin
      free_fifo[i] = (i + 1 < ID_SPACE) ? ENTITY_W'(i + 1) : '0;
      tag_mem[i]   = '0;
    end
    fifo_rd = '0;
    fifo_wr = ENTITY_W'(ID_SPACE - 1);
    free_n  = LIVE_W'(ID_SPACE - 1);
    live_n  = '0;
  endfunction

  function automatic rsp_t alloc_model_step(req_t r);
    rsp_t o;
    o        = '0;
    o.status = STAT_OK;
    case (r.kind)
      KIND_ALLOC: begin
        if (free_n == 0) begin
          o.status = STAT_NO_FREE;
        end else begin
          o.new_id = free_fifo[fifo_rd];
          fifo_rd  = fifo_rd + 1'b1;
          free_n   = free_n - 1'b1;
          live_n   = live_n + 1'b1;
        end
      end
      KIND_RELEASE: begin
        if (int'(r.entity) < ID_SPACE) begin
          if (free_n >= ID_SPACE) begin
            o.status = STAT_LIST_FULL;
          end else begin
            tag_mem[r.entity] = '0;
            free_fifo[fifo_wr] = r.entity;
            fifo_wr = fifo_wr + 1'b1;
            free_n  = free_n + 1'b1;
            if (live_n > 0) live_n = live_n - 1'b1;
          end
        end
      end
      KIND_SET_TAG: begin
        if (int'(r.entity) < ID_SPACE) tag_mem[r.entity] = r.tag_in;
      end
      default: begin
        if (int'(r.entity) < ID_SPACE) o.tag_out = tag_mem[r.entity];
      end
    endcase
    o.live_count = live_n;
    return o;
  endfunction

  // Offers one request, waits for the beat, then records its expected result.
  task automatic send_req(input kind_t k, input logic [ENTITY_W-1:0] ent,
                          input logic [TAG_IO_W-1:0] tag);
    req_t r;
    rsp_t due;
    r.kind   = k;
    r.entity = ent;
    r.tag_in = tag;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= r;
    do @(posedge clk); while (!req_ch.ready);
    due = alloc_model_step(r);
    rsp_due.push_back(due);
    kind_cnt[int'(k)]++;
    if (due.status == STAT_NO_FREE) n_no_free++;
    if (due.status == STAT_LIST_FULL) n_list_full++;
    if (k == KIND_ALLOC && due.status == STAT_OK) held_ids.push_back(due.new_id);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (rsp_due.size() != 0);
  endtask

  // Mostly alloc / tag / release of held IDs; the rest is unconstrained noise.
  task automatic random_req();
    int sel;
    int idx;
    logic [ENTITY_W-1:0] id;
    sel = $urandom_range(3);
    if ($urandom_range(99) < 35) begin
      send_req(kind_t'($urandom_range(3)), ENTITY_W'($urandom), $urandom);
    end else if (held_ids.size() == 0 || (sel == 0 && live_n < 900)) begin
      send_req(KIND_ALLOC, ENTITY_W'($urandom), $urandom);
    end else begin
      idx = $urandom_range(held_ids.size() - 1);
      id  = held_ids[idx];
      case (sel)
        1: send_req(KIND_SET_TAG, id, $urandom);
        2: send_req(KIND_GET_TAG, id, $urandom);
        default: begin
          held_ids.delete(idx);
          send_req(KIND_RELEASE, id, $urandom);
        end
      endcase
    end
  endtask

  task automatic test_directed_edges();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_req(KIND_GET_TAG, 10'd0, 32'hFFFF_FFFF);
    send_req(KIND_GET_TAG, 10'd1023, 32'h0);
    // release with nothing live: count saturates, ring becomes full
    send_req(KIND_RELEASE, 10'd0, 32'h0);
    send_req(KIND_RELEASE, 10'd5, 32'hFFFF_FFFF);
    send_req(KIND_RELEASE, 10'd1023, 32'h0);
    send_req(KIND_ALLOC, 10'd1023, 32'hFFFF_FFFF);
    send_req(KIND_ALLOC, 10'd0, 32'h0);
    send_req(KIND_SET_TAG, 10'd1, 32'hFFFF_FFFF);
    send_req(KIND_GET_TAG, 10'd1, 32'h0);
    send_req(KIND_SET_TAG, 10'd1023, 32'hAAAA_AAAA);
    send_req(KIND_GET_TAG, 10'd1023, 32'h0);
    send_req(KIND_SET_TAG, 10'd2, 32'h5555_5555);
    send_req(KIND_GET_TAG, 10'd2, 32'h0);
    send_req(KIND_RELEASE, 10'd1, 32'h0);
    send_req(KIND_GET_TAG, 10'd1, 32'h0);
    // duplicate release is taken as-is
    send_req(KIND_RELEASE, 10'd1, 32'h0);
    send_req(KIND_RELEASE, 10'd2, 32'h0);
    send_req(KIND_SET_TAG, 10'd700, 32'h0000_0001);
    send_req(KIND_GET_TAG, 10'd700, 32'h0);
    send_req(KIND_SET_TAG, 10'd0, 32'h8000_0000);
    send_req(KIND_RELEASE, 10'd1023, 32'h0);
    send_req(KIND_ALLOC, 10'd512, 32'h0);
    drain_results();
    held_ids.delete();
  endtask

  // Allocation stream under one idling mix; stops early once the list is dry.
  task automatic test_alloc_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count && free_n != 0; i++) begin
      send_req(KIND_ALLOC, ENTITY_W'($urandom), $urandom);
    end
    drain_results();
  endtask

  task automatic test_exhaust_free_list();
    logic [ENTITY_W-1:0] id;
    send_idle_pct  = 10;
    recv_stall_pct = 20;
    send_req(KIND_ALLOC, 10'd0, 32'h0);
    send_req(KIND_ALLOC, 10'd1023, 32'hFFFF_FFFF);
    id = held_ids.pop_front();
    send_req(KIND_SET_TAG, id, $urandom);
    send_req(KIND_GET_TAG, id, 32'h0);
    send_req(KIND_RELEASE, id, 32'h0);
    send_req(KIND_ALLOC, 10'd0, 32'h0);
    send_req(KIND_GET_TAG, id, 32'h0);
    // hand a few back so the mixed traffic has IDs to work on
    repeat (20) begin
      id = held_ids.pop_front();
      send_req(KIND_RELEASE, id, $urandom);
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = HOLD_LEN;
    repeat (30) random_req();
    drain_results();
    repeat (10) random_req();
    drain_results();
  endtask

  // Result side: random stalls, long hold on request, in-order compare.
  initial rsp_ch.ready = 1'b0;

  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    got = rsp_ch.payload;
    if (rsp_ch.valid && rsp_ch.ready) begin
      n_results++;
      if (rsp_due.size() == 0) begin
        errors++;
        if (shown < MAX_SHOWN) begin
          shown++;
          $display("unexpected result beat: status=%0d new_id=%0d tag_out=%h live=%0d",
                   got.status, got.new_id, got.tag_out, got.live_count);
        end
      end else begin
        want = rsp_due.pop_front();
        if (got.status !== want.status || got.new_id !== want.new_id ||
            got.tag_out !== want.tag_out || got.live_count !== want.live_count) begin
          errors++;
          if (shown < MAX_SHOWN) begin
            shown++;
            $display("result %0d mismatch: exp status=%0d new_id=%0d tag_out=%h live=%0d",
                     n_results, want.status, want.new_id, want.tag_out, want.live_count);
            $display("                   got status=%0d new_id=%0d tag_out=%h live=%0d",
                     got.status, got.new_id, got.tag_out, got.live_count);
          end
        end
      end
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: cycles without any beat on either channel
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles", WDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    hold_left      = 0;
    idle_cycles    = 0;
    errors         = 0;
    shown          = 0;
    n_results      = 0;
    n_no_free      = 0;
    n_list_full    = 0;
    kind_cnt       = '{default: 0};
    alloc_model_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_alloc_phase(0, 0, 256);
    test_alloc_phase(71, 0, 256);
    test_alloc_phase(0, 71, 256);
    test_alloc_phase(38, 38, ID_SPACE);
    test_exhaust_free_list();
    test_backpressure();

    repeat (8) @(posedge clk);
    errors += rsp_due.size();
    $display("requests: alloc %0d, release %0d, set tag %0d, get tag %0d; %0d results checked",
             kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3], n_results);
    $display("free list ran dry %0d times, release on full list %0d times, %0d errors",
             n_no_free, n_list_full, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
